### hw/rtl/vps_pkg.sv
// ---------------------------------------------------------------------------
// vps_pkg
// Shared types and constants of the Verlet particle step with wall bounce.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vps_pkg;

  // pipeline depth, input register to output register
  localparam int unsigned NumStages = 7;

  // 300.0 in Q16.16
  localparam logic [32:0] GravAccel = 33'd19660800;

  // register reset values
  localparam logic        GravityOnRst    = 1'b1;
  localparam logic [16:0] DragFactorRst   = 17'd65536;
  localparam logic [16:0] BounceFactorRst = 17'd32768;
  localparam logic [30:0] AreaWidthRst    = 31'd67108864;
  localparam logic [30:0] AreaHeightRst   = 31'd50331648;
  localparam logic [30:0] RadiusRst       = 31'd327680;

  // register indexes
  typedef enum logic [2:0] {
    CfgGravityOn    = 3'd0,
    CfgDragFactor   = 3'd1,
    CfgBounceFactor = 3'd2,
    CfgAreaWidth    = 3'd3,
    CfgAreaHeight   = 3'd4,
    CfgRadius       = 3'd5
  } cfg_idx_e;

  // one enable per pipeline stage
  typedef logic [NumStages-1:0] stage_vec_t;

  typedef struct packed {
    logic        gravity_on;
    logic [16:0] drag_factor;
    logic [16:0] bounce_factor;
    logic [30:0] area_width;
    logic [30:0] area_height;
    logic [30:0] particle_radius;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic        [15:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_prev_x;
    logic signed [31:0] new_prev_y;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/vps_cfg_regs.sv
// ---------------------------------------------------------------------------
// vps_cfg_regs
// Configuration register file, written one register per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vps_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i,
  output vps_pkg::cfg_t      cfg_o
);

  vps_pkg::cfg_t cfg_q, cfg_d;

  // always able to take a write
  assign cfg_ready_o = 1'b1;

  // decode register index, unknown indexes ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (vps_pkg::cfg_idx_e'(cfg_index_i))
        vps_pkg::CfgGravityOn:    cfg_d.gravity_on      = cfg_data_i[0];
        vps_pkg::CfgDragFactor:   cfg_d.drag_factor     = cfg_data_i[16:0];
        vps_pkg::CfgBounceFactor: cfg_d.bounce_factor   = cfg_data_i[16:0];
        vps_pkg::CfgAreaWidth:    cfg_d.area_width      = cfg_data_i[30:0];
        vps_pkg::CfgAreaHeight:   cfg_d.area_height     = cfg_data_i[30:0];
        vps_pkg::CfgRadius:       cfg_d.particle_radius = cfg_data_i[30:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_on      <= vps_pkg::GravityOnRst;
      cfg_q.drag_factor     <= vps_pkg::DragFactorRst;
      cfg_q.bounce_factor   <= vps_pkg::BounceFactorRst;
      cfg_q.area_width      <= vps_pkg::AreaWidthRst;
      cfg_q.area_height     <= vps_pkg::AreaHeightRst;
      cfg_q.particle_radius <= vps_pkg::RadiusRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/vps_pipe_ctrl.sv
// ---------------------------------------------------------------------------
// vps_pipe_ctrl
// Valid bits and per-stage enables of the stallable datapath pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vps_pipe_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output vps_pkg::stage_vec_t en_o
);

  localparam int unsigned Last = vps_pkg::NumStages - 1;

  vps_pkg::stage_vec_t valid_q, valid_d;
  vps_pkg::stage_vec_t en;

  // a stage moves when it is empty or the next stage moves
  always_comb begin
    en[Last] = !valid_q[Last] || !out_stall_i;
    for (int k = Last - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // valid bits travel with the data
  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k <= Last; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en_o        = en;
  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[Last];

endmodule

`default_nettype wire

### hw/rtl/vps_axis_pipe.sv
// ---------------------------------------------------------------------------
// vps_axis_pipe
// One axis of the Verlet step: integrate, wall clamp, bounce and saturate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vps_axis_pipe (
  input  wire logic               clk_i,
  input  wire vps_pkg::stage_vec_t en_i,
  input  wire logic [16:0]        drag_i,
  input  wire logic [16:0]        bounce_i,
  input  wire logic [30:0]        hi_edge_i,
  input  wire logic [30:0]        radius_i,
  input  wire logic signed [31:0] pos_i,
  input  wire logic signed [31:0] prev_i,
  input  wire logic signed [32:0] acc_i,
  input  wire logic        [23:0] dt2_i,
  output logic signed [31:0]      new_pos_o,
  output logic signed [31:0]      new_prev_o
);

  // clamp a wide value to Q15.16
  function automatic logic [31:0] sat32(input logic signed [38:0] v);
    logic [31:0] r;
    if (v[38:31] == {8{v[38]}}) begin
      r = v[31:0];
    end else if (v[38]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // stage 1: velocity
  logic signed [32:0] vel_q;
  logic signed [32:0] acc_q;
  logic signed [31:0] pos1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      vel_q  <= 33'(pos_i) - 33'(prev_i);
      acc_q  <= acc_i;
      pos1_q <= pos_i;
    end
  end

  // stage 2: drag and dt squared products
  logic signed [50:0] prod_v_q;
  logic signed [57:0] prod_a_q;
  logic signed [31:0] pos2_q;
  logic signed [17:0] drag_s;
  logic signed [24:0] dt2_s;

  assign drag_s = $signed({1'b0, drag_i});
  assign dt2_s  = $signed({1'b0, dt2_i});

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_v_q <= 51'(vel_q) * 51'(drag_s);
      prod_a_q <= 58'(acc_q) * 58'(dt2_s);
      pos2_q   <= pos1_q;
    end
  end

  // stage 3: round to Q18.16 and Q17.16
  logic signed [50:0] rnd_v;
  logic signed [57:0] rnd_a;
  logic signed [34:0] dv_q;
  logic signed [33:0] da_q;
  logic signed [31:0] pos3_q;

  assign rnd_v = prod_v_q + 51'sd32768;
  assign rnd_a = prod_a_q + 58'sd8388608;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dv_q   <= rnd_v[50:16];
      da_q   <= rnd_a[57:24];
      pos3_q <= pos2_q;
    end
  end

  // stage 4: new position and its displacement
  logic signed [36:0] np_q;
  logic signed [35:0] disp_q;
  logic signed [31:0] pos4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      np_q   <= 37'(pos3_q) + 37'(dv_q) + 37'(da_q);
      disp_q <= 36'(dv_q) + 36'(da_q);
      pos4_q <= pos3_q;
    end
  end

  // stage 5: restitution product and wall decisions, left/top then right/bottom
  logic signed [31:0] lim32;
  logic signed [36:0] lim;
  logic signed [36:0] rad;
  logic signed [36:0] np_c1;
  logic               lo_hit;
  logic               hi_hit;
  logic signed [17:0] bounce_s;
  logic signed [53:0] prod_b_q;
  logic signed [36:0] npw_q;
  logic               hit5_q;
  logic signed [31:0] pos5_q;

  assign lim32    = $signed({1'b0, hi_edge_i}) - $signed({1'b0, radius_i});
  assign lim      = 37'(lim32);
  assign rad      = $signed({6'b0, radius_i});
  assign bounce_s = $signed({1'b0, bounce_i});
  assign lo_hit   = np_q < rad;
  assign np_c1    = lo_hit ? rad : np_q;
  assign hi_hit   = np_c1 > lim;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      prod_b_q <= 54'(disp_q) * 54'(bounce_s);
      npw_q    <= hi_hit ? lim : np_c1;
      hit5_q   <= lo_hit || hi_hit;
      pos5_q   <= pos4_q;
    end
  end

  // stage 6: round bounce velocity
  logic signed [53:0] rnd_b;
  logic signed [37:0] bv_q;
  logic signed [36:0] npw6_q;
  logic               hit6_q;
  logic signed [31:0] pos6_q;

  assign rnd_b = prod_b_q + 54'sd32768;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      bv_q   <= rnd_b[53:16];
      npw6_q <= npw_q;
      hit6_q <= hit5_q;
      pos6_q <= pos5_q;
    end
  end

  // stage 7: reflected previous position and saturation
  logic signed [38:0] pp;
  logic [31:0]        new_pos_q;
  logic [31:0]        new_prev_q;

  assign pp = hit6_q ? (39'(npw6_q) + 39'(bv_q)) : 39'(pos6_q);

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      new_pos_q  <= sat32(39'(npw6_q));
      new_prev_q <= sat32(pp);
    end
  end

  assign new_pos_o  = $signed(new_pos_q);
  assign new_prev_o = $signed(new_prev_q);

endmodule

`default_nettype wire

### hw/rtl/verlet_particle_step_with_walls_core.sv
// Throughput: one particle per cycle while the output is not stalled, through the seven-stage datapath per axis.
// Stalls hold every stage that cannot move; bubbles close up.
// Reset clears all valid bits and loads the register reset values.
// ---------------------------------------------------------------------------
// verlet_particle_step_with_walls_core
// Fixed-point position-Verlet step of one 2D particle with wall bounce.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module verlet_particle_step_with_walls_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire vps_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output vps_pkg::out_item_t     out_data_o
);

  vps_pkg::cfg_t       cfg;
  vps_pkg::stage_vec_t en;

  vps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vps_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .en_o        (en)
  );

  // gravity on the y acceleration
  logic signed [32:0] acc_y;
  logic signed [32:0] acc_x;

  assign acc_x = 33'(in_data_i.accel_x);
  assign acc_y = 33'(in_data_i.accel_y)
               + (cfg.gravity_on ? $signed(vps_pkg::GravAccel) : 33'sd0);

  // dt squared, Q0.24, shared by both axes
  logic [31:0] dt_sq;
  logic [32:0] dt_sq_rnd;
  logic [23:0] dt2_q;

  assign dt_sq     = 32'(in_data_i.time_step) * 32'(in_data_i.time_step);
  assign dt_sq_rnd = {1'b0, dt_sq} + 33'd128;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dt2_q <= dt_sq_rnd[31:8];
    end
  end

  // per-axis results
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_prev_x;
  logic signed [31:0] new_prev_y;

  vps_axis_pipe u_axis_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .drag_i     (cfg.drag_factor),
    .bounce_i   (cfg.bounce_factor),
    .hi_edge_i  (cfg.area_width),
    .radius_i   (cfg.particle_radius),
    .pos_i      (in_data_i.pos_x),
    .prev_i     (in_data_i.prev_x),
    .acc_i      (acc_x),
    .dt2_i      (dt2_q),
    .new_pos_o  (new_pos_x),
    .new_prev_o (new_prev_x)
  );

  vps_axis_pipe u_axis_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .drag_i     (cfg.drag_factor),
    .bounce_i   (cfg.bounce_factor),
    .hi_edge_i  (cfg.area_height),
    .radius_i   (cfg.particle_radius),
    .pos_i      (in_data_i.pos_y),
    .prev_i     (in_data_i.prev_y),
    .acc_i      (acc_y),
    .dt2_i      (dt2_q),
    .new_pos_o  (new_pos_y),
    .new_prev_o (new_prev_y)
  );

  // result transaction
  assign out_data_o = {new_pos_x, new_pos_y, new_prev_x, new_prev_y};

endmodule

`default_nettype wire

### bench/verlet_particle_step_with_walls_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// verlet_particle_step_with_walls_core_tb
// Self-checking bench for the fixed-point Verlet particle step with walls.
// A clocked driver feeds particles from a queue, a clocked monitor compares
// every result transaction with a prediction made at input acceptance. The
// run steps through several register settings, from all-zero to the reset
// values, with random idling on both channels and one long output hold.
// ---------------------------------------------------------------------------
module verlet_particle_step_with_walls_core_tb;

  localparam int unsigned HalfPeriod  = 2;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseItems  = 122;
  localparam int unsigned HoldAt      = 300;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned TimeoutNs   = 2_000_000;
  localparam int unsigned Unit        = 65536;
  localparam logic [2:0]  CfgNoReg    = 3'd6;
  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  typedef struct packed {
    logic [31:0] gravity, drag, bounce, width, height, radius;
  } reg_set_t;

  // dut signals
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic      cfg_ready;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  vps_pkg::in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  vps_pkg::out_item_t out_data;

  // predictor copy of the registers
  logic        grav_en      = vps_pkg::GravityOnRst;
  logic [16:0] drag_scale   = vps_pkg::DragFactorRst;
  logic [16:0] bounce_scale = vps_pkg::BounceFactorRst;
  logic [30:0] wall_right   = vps_pkg::AreaWidthRst;
  logic [30:0] wall_bottom  = vps_pkg::AreaHeightRst;
  logic [30:0] radius       = vps_pkg::RadiusRst;

  // bench bookkeeping
  vps_pkg::in_item_t  particles_to_send[$];
  vps_pkg::out_item_t predicted_states[$];
  reg_set_t    phase_regs[NumPhases];
  logic        quiet      = 1'b0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_writes   = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;

  verlet_particle_step_with_walls_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // clock
  always #(HalfPeriod) clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // divide by 2^s, halves rounded towards +infinity
  function automatic longint round_shift(longint v, int unsigned s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp_q16(longint v);
    if (v > longint'(QMax)) return QMax;
    if (v < longint'(QMin)) return QMin;
    return v[31:0];
  endfunction

  // one axis: integrate, then low wall, then high wall on the clamped value
  function automatic void integrate_axis(input longint pos, prev, acc, dt2, hi_wall,
                                         output logic signed [31:0] new_pos, new_prev);
    longint r, np, bv, pp, lim;
    r   = longint'(radius);
    np  = pos + round_shift((pos - prev) * longint'(drag_scale), 16)
              + round_shift(acc * dt2, 24);
    bv  = round_shift((np - pos) * longint'(bounce_scale), 16);
    pp  = pos;
    lim = hi_wall - r;
    if (np < r) begin
      np = r;
      pp = np + bv;
    end
    if (np > lim) begin
      np = lim;
      pp = np + bv;
    end
    new_pos  = clamp_q16(np);
    new_prev = clamp_q16(pp);
  endfunction

  function automatic vps_pkg::out_item_t predict_step(vps_pkg::in_item_t p);
    vps_pkg::out_item_t res;
    longint    dt, dt2, ay;
    dt  = longint'(p.time_step);
    dt2 = round_shift(dt * dt, 8);
    ay  = longint'($signed(p.accel_y))
        + (grav_en ? longint'(vps_pkg::GravAccel) : 64'sd0);
    integrate_axis(longint'($signed(p.pos_x)), longint'($signed(p.prev_x)),
                   longint'($signed(p.accel_x)), dt2, longint'(wall_right),
                   res.new_pos_x, res.new_prev_x);
    integrate_axis(longint'($signed(p.pos_y)), longint'($signed(p.prev_y)),
                   ay, dt2, longint'(wall_bottom),
                   res.new_pos_y, res.new_prev_y);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic vps_pkg::in_item_t mk(input logic [31:0] px, py, qx, qy, ax, ay,
                                           input logic [15:0] dt);
    vps_pkg::in_item_t p;
    p.pos_x     = px;
    p.pos_y     = py;
    p.prev_x    = qx;
    p.prev_y    = qy;
    p.accel_x   = ax;
    p.accel_y   = ay;
    p.time_step = dt;
    return p;
  endfunction

  function automatic logic [31:0] pick_corner();
    case ($urandom_range(5))
      0:       return QMax;
      1:       return QMin;
      2:       return '0;
      3:       return '1;
      4:       return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // signed random value in [-n, n]
  function automatic longint rand_span(int unsigned n);
    return longint'($urandom_range(2 * n)) - longint'(n);
  endfunction

  // coordinate near the low wall, near the high wall or anywhere inside
  function automatic longint place_coord(longint hi_wall);
    longint r;
    r = longint'(radius);
    case ($urandom_range(2))
      0:       return r + rand_span(4 * Unit);
      1:       return hi_wall - r + rand_span(4 * Unit);
      default: return longint'($urandom_range(32'(hi_wall)));
    endcase
  endfunction

  // mostly plausible particles, some full-range noise and corner values
  function automatic vps_pkg::in_item_t gen_particle();
    vps_pkg::in_item_t p;
    longint   x, y;
    case ($urandom_range(9))
      0, 1: begin
        p = mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               16'($urandom()));
      end
      2: begin
        p = mk(pick_corner(), pick_corner(), pick_corner(), pick_corner(), pick_corner(),
               pick_corner(), 16'(pick_corner()));
      end
      default: begin
        x = place_coord(longint'(wall_right));
        y = place_coord(longint'(wall_bottom));
        p = mk(32'(x), 32'(y), 32'(x - rand_span(6 * Unit)), 32'(y - rand_span(6 * Unit)),
               32'(rand_span(2000 * Unit)), 32'(rand_span(2000 * Unit)),
               ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(2000, 500)));
      end
    endcase
    return p;
  endfunction

  // one register write transaction, then mirror it in the predictor
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      vps_pkg::CfgGravityOn:    grav_en      = val[0];
      vps_pkg::CfgDragFactor:   drag_scale   = val[16:0];
      vps_pkg::CfgBounceFactor: bounce_scale = val[16:0];
      vps_pkg::CfgAreaWidth:    wall_right   = val[30:0];
      vps_pkg::CfgAreaHeight:   wall_bottom  = val[30:0];
      vps_pkg::CfgRadius:       radius       = val[30:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  // wait until all particles are in and all results are back
  task automatic wait_idle();
    do @(negedge clk);
    while (particles_to_send.size() != 0 || in_valid || predicted_states.size() != 0);
    repeat (vps_pkg::NumStages + 3) @(posedge clk);
  endtask

  task automatic check_field(string label, logic signed [31:0] want, got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= MaxReports)
        $display("mismatch %s in result %0d: expected %0d (%h), got %0d (%h)",
                 label, n_checked, want, want, got, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued particles, predicts each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : tx_side
    if (in_valid && !in_stall) begin
      predicted_states.push_back(predict_step(in_data));
      n_accepted <= n_accepted + 1;
    end
    // a stalled transaction stays as it is
    if (!(in_valid && in_stall)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (particles_to_send.size() != 0) begin
        if (!quiet && $urandom_range(5) == 0) begin
          gap_left = $urandom_range(5, 0);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= particles_to_send.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares results, drives random output stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_side
    vps_pkg::out_item_t want;
    if (out_valid && !out_stall) begin
      if (predicted_states.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("unexpected result transaction: %h", out_data);
      end else begin
        want = predicted_states.pop_front();
        check_field("new_pos_x",  want.new_pos_x,  out_data.new_pos_x);
        check_field("new_pos_y",  want.new_pos_y,  out_data.new_pos_y);
        check_field("new_prev_x", want.new_prev_x, out_data.new_prev_x);
        check_field("new_prev_y", want.new_prev_y, out_data.new_prev_y);
        n_checked++;
      end
    end
    if (stall_left != 0)
      stall_left--;
    else if (!quiet && rst_n && $urandom_range(5) == 0)
      stall_left = $urandom_range(6, 1);
    out_stall <= (stall_left != 0) || (hold_left != 0);
  end

  // long output hold once the run is well under way, so the pipeline fills
  always @(posedge clk) begin : long_hold
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    // all zero, unit scales with the widest area, scales above one and a narrow area,
    // radius at maximum, random with junk upper bits, back to reset values
    phase_regs[0] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    phase_regs[1] = '{32'd1, 32'd65536, 32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0};
    phase_regs[2] = '{32'd0, 32'h1_FFFF, 32'h1_FFFF, 10 * Unit, 6 * Unit, 8 * Unit};
    phase_regs[3] = '{32'hFFFF_FFFF, 32'd64880, 32'd52429, 800 * Unit, 600 * Unit,
                      32'h7FFF_FFFF};
    phase_regs[4] = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom()};
    phase_regs[5] = '{32'(vps_pkg::GravityOnRst), 32'(vps_pkg::DragFactorRst),
                      32'(vps_pkg::BounceFactorRst), 32'(vps_pkg::AreaWidthRst),
                      32'(vps_pkg::AreaHeightRst), 32'(vps_pkg::RadiusRst)};

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed particles under reset settings
    particles_to_send.push_back(mk(0, 0, 0, 0, 0, 0, 16'd0));
    particles_to_send.push_back(mk(QMax, QMax, QMax, QMax, QMax, QMax, 16'hFFFF));
    particles_to_send.push_back(mk(QMin, QMin, QMin, QMin, QMin, QMin, 16'hFFFF));
    particles_to_send.push_back(mk(512 * Unit, 384 * Unit, 512 * Unit, 384 * Unit, 0, 0,
                                   16'd1092));
    // left, right, top and bottom wall contacts
    particles_to_send.push_back(mk(3 * Unit, 300 * Unit, 7 * Unit, 300 * Unit, 0, 0,
                                   16'd1092));
    particles_to_send.push_back(mk(1021 * Unit, 300 * Unit, 1017 * Unit, 300 * Unit, 0, 0,
                                   16'd1092));
    particles_to_send.push_back(mk(300 * Unit, 2 * Unit, 300 * Unit, 6 * Unit, 0, 0,
                                   16'd1092));
    particles_to_send.push_back(mk(300 * Unit, 766 * Unit, 300 * Unit, 760 * Unit, 0, 0,
                                   16'd1092));
    // two walls at once in opposite corners
    particles_to_send.push_back(mk(1 * Unit, 1 * Unit, 4 * Unit, 4 * Unit, 0, 0, 16'd1092));
    particles_to_send.push_back(mk(1023 * Unit, 767 * Unit, 1020 * Unit, 764 * Unit, 0, 0,
                                   16'd1092));
    // velocity beyond 32 bits, reflected previous saturates
    particles_to_send.push_back(mk(QMax, 0, QMin, 0, 0, 0, 16'd0));
    particles_to_send.push_back(mk(QMin, QMin, QMin, QMax, 0, 0, 16'd0));
    // exact halves in the acceleration term, positive and negative
    particles_to_send.push_back(mk(512 * Unit, 384 * Unit, 512 * Unit, 384 * Unit,
                                   32'd8388608, 32'hFF80_0000, 16'd16));
    particles_to_send.push_back(mk(512 * Unit, 384 * Unit, 512 * Unit, 384 * Unit,
                                   32'hFF80_0000, 32'd8388608, 16'd16));
    particles_to_send.push_back(mk(512 * Unit, 384 * Unit, 511 * Unit, 385 * Unit,
                                   100 * Unit, 100 * Unit, 16'd1));
    particles_to_send.push_back(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                                   32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA));
    particles_to_send.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                   32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555));
    particles_to_send.push_back(mk(512 * Unit, 384 * Unit, 512 * Unit, 384 * Unit, QMax,
                                   QMin, 16'hFFFF));
    wait_idle();

    // register settings, each followed by random particles
    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) quiet <= 1'b1;
      write_reg(vps_pkg::CfgGravityOn,    phase_regs[p].gravity);
      write_reg(vps_pkg::CfgDragFactor,   phase_regs[p].drag);
      write_reg(vps_pkg::CfgBounceFactor, phase_regs[p].bounce);
      write_reg(vps_pkg::CfgAreaWidth,    phase_regs[p].width);
      write_reg(vps_pkg::CfgAreaHeight,   phase_regs[p].height);
      write_reg(vps_pkg::CfgRadius,       phase_regs[p].radius);
      // a write to an unused index must change nothing
      if (p == 1) write_reg(CfgNoReg, $urandom());
      repeat (PhaseItems) particles_to_send.push_back(gen_particle());
      wait_idle();
    end

    repeat (2 * vps_pkg::NumStages) @(posedge clk);
    $display("%0d particles sent under %0d register settings, %0d results compared",
             n_accepted, NumPhases + 1, n_checked);
    $display("%0d register writes, one long output hold of %0d cycles",
             n_writes, HoldCycles);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TimeoutNs);
    $display("timeout with %0d results outstanding", predicted_states.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### verlet_particle_step_with_walls_core.f
hw/rtl/vps_pkg.sv
hw/rtl/vps_cfg_regs.sv
hw/rtl/vps_pipe_ctrl.sv
hw/rtl/vps_axis_pipe.sv
hw/rtl/verlet_particle_step_with_walls_core.sv
bench/verlet_particle_step_with_walls_core_tb.sv
